[rtl/core/lonlat_to_mercator_tile_top_defines.svh]
// Assertion macros shared by the tile index RTL.
// Used by lonlat_to_mercator_tile_top; expects clk and rst_n in scope.
`ifndef LONLAT_TO_MERCATOR_TILE_TOP_DEFINES_SVH
`define LONLAT_TO_MERCATOR_TILE_TOP_DEFINES_SVH

// Clocked assertion, switched off while reset is held
`define LMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication built on the macro above
`define LMT_ASSERT_IMP(label, cond, cons, msg) \
  `LMT_ASSERT(label, (cond) |-> (cons), msg)

`endif

[rtl/core/lmt_pkg.sv]
// Package for the Web Mercator tile index block: types, constants, CORDIC tables.
// No dependencies; used by lonlat_to_mercator_tile_top, lmt_circ_cell, lmt_hyp_cell and lmt_norm.
`default_nettype none

package lmt_pkg;

  localparam int MAX_ZOOM   = 24;
  localparam int ANGLE_BITS = 32;
  localparam int ABIN_BITS  = ANGLE_BITS - 1;

  localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
  localparam logic [63:0] HALF_Q60   = 64'h0800_0000_0000_0000;
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] LN2_Q60    = 64'h0B17217F7D1CF79A;
  localparam logic [63:0] INV2PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0] TINY_Q60   = 64'h0004_0000_0000_0000;

  localparam int CIRC_STEPS = 62;
  localparam int HYP_STEPS  = 64;

  // Pipeline stage numbers
  localparam int STG_MUL0 = 1;
  localparam int STG_CIRC = 3;
  localparam int STG_NORM = STG_CIRC + CIRC_STEPS;
  localparam int STG_HYP  = STG_NORM + 2;
  localparam int STG_PSI  = STG_HYP + HYP_STEPS;
  localparam int STG_MULT = STG_PSI + 1;
  localparam int STAGES   = STG_MULT + 4;

  typedef enum logic [1:0] {
    SIDE_NONE,
    SIDE_SOUTH,
    SIDE_NORTH
  } side_t;

  typedef struct packed {
    logic [23:0] col;
    logic [4:0]  zoom;
    side_t       side;
  } sb_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] e;
  } hvec_t;

  typedef logic [63:0] tab_t [64];
  typedef logic [5:0]  seq_t [64];

  // Restoring long division, elaboration use only
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Truncated series for atan (alt) or atanh of 2^-i, Q60
  function automatic logic [63:0] arc_series(input int i, input logic alt);
    logic [63:0] sum;
    logic [63:0] t;
    int n;
    sum = '0;
    for (int k = 0; k < 31; k++) begin
      n = i * (2 * k + 1);
      if (n <= 60) begin
        t = udiv(ONE_Q60 >> n, 64'(2 * k + 1));
        if (alt && ((k & 1) == 1)) sum = sum - t;
        else sum = sum + t;
      end
    end
    return sum;
  endfunction

  function automatic tab_t build_atan();
    tab_t tb;
    tb[0] = PI_Q60 >> 2;
    for (int i = 1; i < 64; i++) tb[i] = arc_series(i, 1'b1);
    return tb;
  endfunction

  function automatic tab_t build_atanh();
    tab_t tb;
    tb[0] = '0;
    for (int i = 1; i < 64; i++) tb[i] = arc_series(i, 1'b0);
    return tb;
  endfunction

  // Hyperbolic shift order: 1..61, with 4, 13 and 40 repeated
  function automatic seq_t build_seq();
    seq_t sq;
    int j;
    j = 0;
    for (int i = 1; i <= 61; i++) begin
      sq[j] = 6'(i);
      j++;
      if (i == 4 || i == 13 || i == 40) begin
        sq[j] = 6'(i);
        j++;
      end
    end
    return sq;
  endfunction

  localparam tab_t ATAN_TAB  = build_atan();
  localparam tab_t ATANH_TAB = build_atanh();
  localparam seq_t HYP_SEQ   = build_seq();

endpackage

`default_nettype wire

[rtl/core/lmt_in_if.sv]
// Input channel: valid/ready plus one coordinate beat.
// No dependencies.
`default_nettype none

interface lmt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] longitude;
  logic signed [31:0] latitude;
  logic [4:0]         zoom_level;

  modport source (output valid, longitude, latitude, zoom_level, input ready);
  modport sink   (input valid, longitude, latitude, zoom_level, output ready);
endinterface

`default_nettype wire

[rtl/core/lmt_out_if.sv]
// Result channel: valid/ready plus one tile index beat.
// No dependencies.
`default_nettype none

interface lmt_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] tile_column;
  logic [23:0] tile_row;
  logic        row_saturated;

  modport source (output valid, tile_column, tile_row, row_saturated, input ready);
  modport sink   (input valid, tile_column, tile_row, row_saturated, output ready);
endinterface

`default_nettype wire

[rtl/core/lonlat_to_mercator_tile_top.sv]
// Top level of the Web Mercator tile index block: pipeline of CORDIC cells.
// Depends on lmt_pkg, lmt_in_if, lmt_out_if, lmt_circ_cell, lmt_hyp_cell, lmt_norm.
//
//  channel | dir | payload                                   | handshake
//  in_ch   | in  | longitude, latitude, zoom_level           | valid/ready
//  out_ch  | out | tile_column, tile_row, row_saturated      | valid/ready
//
// One beat accepted per cycle while the skid register is empty; the depth from acceptance
// to the output register is set by 62 circular and 64 hyperbolic (per lane) CORDIC cells,
// split multipliers and a two-stage normaliser.
// Reset (rst_n low, synchronous) empties the pipeline and the output stages.
// The whole pipeline holds while the skid register is full; it fills when a
// result meets a stalled output register, so in_ch.ready drops in the following cycle.
`default_nettype none
`include "lonlat_to_mercator_tile_top_defines.svh"

module lonlat_to_mercator_tile_top (
  input  wire logic clk,
  input  wire logic rst_n,
  lmt_in_if.sink    in_ch,
  lmt_out_if.source out_ch
);

  localparam int L = lmt_pkg::STAGES;

  logic en;

  // sideband and valid line
  logic         vld_r [L];
  lmt_pkg::sb_t sb_r  [L];
  lmt_pkg::sb_t sb_nxt [L];

  // stage 0
  logic [lmt_pkg::ABIN_BITS-1:0] abin_r, abin1_r;
  logic [4:0]  zc;
  logic [31:0] lonoff;
  logic signed [33:0] abin_s;
  lmt_pkg::side_t side0;
  // stage 1/2
  logic [63:0] m1_r;
  logic [95:0] zprod;
  lmt_pkg::vec_t z2_r;
  // cell chains
  lmt_pkg::vec_t  cv [lmt_pkg::CIRC_STEPS+1];
  lmt_pkg::hvec_t hy [lmt_pkg::HYP_STEPS+1];
  lmt_pkg::hvec_t hx [lmt_pkg::HYP_STEPS+1];
  // psi and product
  logic signed [63:0] psi;
  logic [63:0]  mag_r [4];
  logic         neg_r [5];
  logic [127:0] acc_r [4];
  // final
  logic [63:0] qv;
  logic signed [63:0] yq;
  logic [23:0] fin_row;
  logic        fin_sat;
  logic [24:0] north_row;
  // output and skid
  logic        out_v_r, skid_v_r, out_free, take;
  logic [23:0] out_col_r, out_row_r, skid_col_r, skid_row_r;
  logic        out_sat_r, skid_sat_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // front end: column, angle offset, pole window; then the sideband shift,
  // with the CORDIC magnitude check joining at the normaliser
  always_comb begin
    zc     = (in_ch.zoom_level > 5'(lmt_pkg::MAX_ZOOM)) ? 5'(lmt_pkg::MAX_ZOOM)
                                                         : in_ch.zoom_level;
    lonoff = {~in_ch.longitude[31], in_ch.longitude[30:0]};
    abin_s = $signed({{2{in_ch.latitude[31]}}, in_ch.latitude}) + 34'sd1073741824;
    if (abin_s <= 34'sd33554432) side0 = lmt_pkg::SIDE_SOUTH;
    else if (abin_s >= 34'sd2113929216) side0 = lmt_pkg::SIDE_NORTH;
    else side0 = lmt_pkg::SIDE_NONE;
    sb_nxt[0].col  = 24'(lonoff >> (6'd32 - {1'b0, zc}));
    sb_nxt[0].zoom = zc;
    sb_nxt[0].side = side0;
    for (int k = 1; k < L; k++) begin
      sb_nxt[k] = sb_r[k-1];
      if (k == lmt_pkg::STG_NORM && sb_r[k-1].side == lmt_pkg::SIDE_NONE) begin
        if (cv[lmt_pkg::CIRC_STEPS].y < $signed(lmt_pkg::TINY_Q60))
          sb_nxt[k].side = lmt_pkg::SIDE_SOUTH;
        else if (cv[lmt_pkg::CIRC_STEPS].x < $signed(lmt_pkg::TINY_Q60))
          sb_nxt[k].side = lmt_pkg::SIDE_NORTH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k < L; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < L; k++) sb_r[k] <= sb_nxt[k];
    end
  end

  // angle times pi, split over two stages
  assign zprod = {32'b0, m1_r}
               + ({35'b0, 61'(abin1_r * lmt_pkg::PI_Q60[61:32])} << 32);

  always_ff @(posedge clk) begin
    if (en) begin
      abin_r  <= abin_s[lmt_pkg::ABIN_BITS-1:0];
      abin1_r <= abin_r;
      m1_r    <= 64'(abin_r * lmt_pkg::PI_Q60[31:0]);
      z2_r.x  <= $signed(lmt_pkg::ONE_Q60);
      z2_r.y  <= '0;
      z2_r.z  <= $signed(zprod[95:32]);
    end
  end

  // circular rotation chain
  assign cv[0] = z2_r;
  for (genvar k = 0; k < lmt_pkg::CIRC_STEPS; k++) begin : g_circ
    lmt_circ_cell u_cell (
      .clk (clk),
      .en  (en),
      .sh  (6'(k)),
      .d   (cv[k]),
      .q   (cv[k+1])
    );
  end

  // log of sine and cosine lanes
  lmt_norm u_norm_y (.clk(clk), .en(en), .v(cv[lmt_pkg::CIRC_STEPS].y), .q(hy[0]));
  lmt_norm u_norm_x (.clk(clk), .en(en), .v(cv[lmt_pkg::CIRC_STEPS].x), .q(hx[0]));

  for (genvar j = 0; j < lmt_pkg::HYP_STEPS; j++) begin : g_hyp
    lmt_hyp_cell u_cell_y (
      .clk (clk),
      .en  (en),
      .sh  (lmt_pkg::HYP_SEQ[j]),
      .d   (hy[j]),
      .q   (hy[j+1])
    );
    lmt_hyp_cell u_cell_x (
      .clk (clk),
      .en  (en),
      .sh  (lmt_pkg::HYP_SEQ[j]),
      .d   (hx[j]),
      .q   (hx[j+1])
    );
  end

  // psi = ln tan a
  assign psi = ((hy[lmt_pkg::HYP_STEPS].z - hx[lmt_pkg::HYP_STEPS].z) <<< 1)
             + (hy[lmt_pkg::HYP_STEPS].e - hx[lmt_pkg::HYP_STEPS].e);

  // |psi| / (2 pi): one 32x32 partial product per stage; sign follows acc_r
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0] <= psi[63] ? 64'(-psi) : 64'(psi);
      neg_r[0] <= psi[63];
      acc_r[0] <= {64'b0, 64'(mag_r[0][31:0] * lmt_pkg::INV2PI_Q64[31:0])};
      for (int s = 1; s < 4; s++) mag_r[s] <= mag_r[s-1];
      for (int s = 1; s < 5; s++) neg_r[s] <= neg_r[s-1];
      acc_r[1] <= acc_r[0]
                + ({64'b0, 64'(mag_r[1][31:0] * lmt_pkg::INV2PI_Q64[63:32])} << 32);
      acc_r[2] <= acc_r[1]
                + ({64'b0, 64'(mag_r[2][63:32] * lmt_pkg::INV2PI_Q64[31:0])} << 32);
      acc_r[3] <= acc_r[2]
                + ({64'b0, 64'(mag_r[3][63:32] * lmt_pkg::INV2PI_Q64[63:32])} << 64);
    end
  end

  // row from yq, clamps
  always_comb begin
    qv        = acc_r[3][127:64];
    yq        = neg_r[4] ? $signed(lmt_pkg::HALF_Q60 - qv) : $signed(lmt_pkg::HALF_Q60 + qv);
    north_row = (25'd1 << sb_r[L-1].zoom) - 25'd1;
    fin_sat   = 1'b1;
    fin_row   = '0;
    case (sb_r[L-1].side)
      lmt_pkg::SIDE_SOUTH: fin_row = '0;
      lmt_pkg::SIDE_NORTH: fin_row = north_row[23:0];
      default: begin
        if (yq[63]) begin
          fin_row = '0;
        end else if (yq >= $signed(lmt_pkg::ONE_Q60)) begin
          fin_row = north_row[23:0];
        end else begin
          fin_row = 24'(yq >> (6'd60 - {1'b0, sb_r[L-1].zoom}));
          fin_sat = 1'b0;
        end
      end
    endcase
  end

  // output register with skid
  assign out_free = !out_v_r || out_ch.ready;
  assign take     = en && vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_free) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (out_free) begin
      out_v_r <= take;
    end else if (take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_free) begin
        out_col_r <= skid_col_r;
        out_row_r <= skid_row_r;
        out_sat_r <= skid_sat_r;
      end
    end else if (out_free) begin
      out_col_r <= sb_r[L-1].col;
      out_row_r <= fin_row;
      out_sat_r <= fin_sat;
    end else begin
      skid_col_r <= sb_r[L-1].col;
      skid_row_r <= fin_row;
      skid_sat_r <= fin_sat;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.tile_column   = out_col_r;
  assign out_ch.tile_row      = out_row_r;
  assign out_ch.row_saturated = out_sat_r;

  // checks
  `LMT_ASSERT_IMP(a_skid_has_out, skid_v_r, out_v_r, "skid full with empty output")
  `LMT_ASSERT(a_skid_holds, (skid_v_r && !out_ch.ready) |=> skid_v_r, "skid beat lost")
  `LMT_ASSERT(a_skid_fill, $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready), "bad skid fill")

endmodule

`default_nettype wire

[rtl/core/lmt_circ_cell.sv]
// One circular CORDIC rotation step, registered.
// Depends on lmt_pkg (vec_t, ATAN_TAB).
`default_nettype none

module lmt_circ_cell (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [5:0]   sh,
  input  wire lmt_pkg::vec_t d,
  output lmt_pkg::vec_t     q
);

  lmt_pkg::vec_t q_r, q_nxt;
  logic signed [63:0] xs, ys, t;

  // rotate toward z = 0
  always_comb begin
    xs = d.x >>> sh;
    ys = d.y >>> sh;
    t  = $signed(lmt_pkg::ATAN_TAB[sh]);
    if (!d.z[63]) begin
      q_nxt.x = d.x - ys;
      q_nxt.y = d.y + xs;
      q_nxt.z = d.z - t;
    end else begin
      q_nxt.x = d.x + ys;
      q_nxt.y = d.y - xs;
      q_nxt.z = d.z + t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

[rtl/core/lmt_hyp_cell.sv]
// One hyperbolic CORDIC vectoring step, registered; exponent term rides along.
// Depends on lmt_pkg (hvec_t, ATANH_TAB).
`default_nettype none

module lmt_hyp_cell (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [5:0]    sh,
  input  wire lmt_pkg::hvec_t d,
  output lmt_pkg::hvec_t     q
);

  lmt_pkg::hvec_t q_r, q_nxt;
  logic signed [63:0] xs, ys, t;

  // drive y toward zero, accumulate atanh
  always_comb begin
    xs = d.x >>> sh;
    ys = d.y >>> sh;
    t  = $signed(lmt_pkg::ATANH_TAB[sh]);
    q_nxt.e = d.e;
    if (!d.y[63]) begin
      q_nxt.x = d.x - ys;
      q_nxt.y = d.y - xs;
      q_nxt.z = d.z + t;
    end else begin
      q_nxt.x = d.x + ys;
      q_nxt.y = d.y + xs;
      q_nxt.z = d.z - t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

[rtl/core/lmt_norm.sv]
// Log front end: leading-one search, then mantissa shift and e*ln2, two stages.
// Depends on lmt_pkg (hvec_t, ONE_Q60, LN2_Q60).
`default_nettype none

module lmt_norm (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [63:0] v,
  output lmt_pkg::hvec_t          q
);

  logic [5:0]         p_r, p_nxt;
  logic [63:0]        v_r;
  lmt_pkg::hvec_t     q_r, q_nxt;
  logic [63:0]        m;
  logic signed [6:0]  ex;

  // leading one among bits 62..0 (zero gives 0)
  always_comb begin
    p_nxt = '0;
    for (int b = 1; b <= 62; b++) begin
      if (v[b]) p_nxt = 6'(b);
    end
  end

  // mantissa in [1,2) and exponent term
  always_comb begin
    if (p_r >= 6'd60) m = v_r >> (p_r - 6'd60);
    else m = v_r << (6'd60 - p_r);
    ex = $signed({1'b0, p_r}) - 7'sd60;
    q_nxt.x = $signed(m + lmt_pkg::ONE_Q60);
    q_nxt.y = $signed(m - lmt_pkg::ONE_Q60);
    q_nxt.z = '0;
    q_nxt.e = 64'(ex * $signed({1'b0, lmt_pkg::LN2_Q60}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
      v_r <= v;
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire
